>>> rtl/cna_pkg.sv
// Package with the operation codes, widths and control flags of the complex ALU.
package cna_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int PORT_WIDTH     = 16;
  localparam int ACT_WIDTH      = 3;

  typedef enum logic [ACT_WIDTH-1:0] {
    ACT_ADD  = 3'd0,
    ACT_SUB  = 3'd1,
    ACT_MUL  = 3'd2,
    ACT_DIV  = 3'd3,
    ACT_EQ   = 3'd4,
    ACT_CONJ = 3'd5
  } action_t;

  // Flags that travel with an item down the pipeline.
  typedef struct packed {
    logic is_div;
    logic is_eq;
    logic is_conj;
    logic is_addsub;
    logic is_mul;
    logic zero_den;
    logic eq_hit;
  } ctl_t;

endpackage

>>> rtl/complex_number_alu_core.sv
// Top level of the pipelined complex arithmetic unit.
//
// The unit takes one transaction per clock unless the result side stalls,
// and returns one result transaction per input, in order. Every item,
// whatever its operation, passes through the same pipeline: an operand
// stage, a product stage, a sum stage, a chain of NUM_W identical division
// cells that each resolve one quotient bit, and a saturation stage that
// feeds the output register. The whole pipeline advances together whenever
// the output register is empty or being taken, so a stall on the result
// side holds every stage; in_stall simply mirrors that. Division follows the
// conjugate rule: the quotient of (a+bi)/(c+di) is ((ac+bd) + (bc-ad)i) *
// 2^FRAC_BITS / (c^2+d^2), truncated toward zero. All results truncate toward
// zero and then saturate, raising the saturated flag. A zero divisor returns
// zero with the divide_by_zero flag.
module complex_number_alu_core #(
  parameter int DATA_WIDTH = cna_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cna_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cna_pkg::ACT_WIDTH-1:0]     in_action,
  input  logic signed [cna_pkg::PORT_WIDTH-1:0] in_first_re,
  input  logic signed [cna_pkg::PORT_WIDTH-1:0] in_first_im,
  input  logic signed [cna_pkg::PORT_WIDTH-1:0] in_second_re,
  input  logic signed [cna_pkg::PORT_WIDTH-1:0] in_second_im,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cna_pkg::PORT_WIDTH-1:0] out_result_re,
  output logic signed [cna_pkg::PORT_WIDTH-1:0] out_result_im,
  output logic                              out_is_equal,
  output logic                              out_divide_by_zero,
  output logic                              out_saturated
);

  localparam int DW    = DATA_WIDTH;
  localparam int PW    = 2 * DW;          // product magnitude width
  localparam int SW    = PW + 1;          // sum magnitude width
  localparam int NUM_W = SW + FRAC_BITS;  // shifted dividend width
  localparam int DEN_W = SW;
  localparam int Q_W   = NUM_W;
  localparam int NCELL = NUM_W;
  localparam int PIPE  = NCELL + 3;

  logic adv;
  logic [PIPE-1:0] vld_r;
  logic out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Operand stage: register the low DATA_WIDTH bits of each operand.
  logic signed [DW-1:0] a_r, b_r, c_r, d_r;
  cna_pkg::ctl_t        ctl0_r;
  logic                 eq0;

  always_comb begin
    eq0 = (in_first_re[DW-1:0] == in_second_re[DW-1:0]) &&
          (in_first_im[DW-1:0] == in_second_im[DW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= in_first_re[DW-1:0];
      b_r <= in_first_im[DW-1:0];
      c_r <= in_second_re[DW-1:0];
      d_r <= in_second_im[DW-1:0];
      ctl0_r.is_addsub <= 1'b0;
      ctl0_r.is_mul    <= (in_action == cna_pkg::ACT_MUL);
      ctl0_r.is_div    <= (in_action == cna_pkg::ACT_DIV);
      ctl0_r.is_eq     <= (in_action == cna_pkg::ACT_EQ);
      ctl0_r.is_conj   <= (in_action == cna_pkg::ACT_CONJ);
      ctl0_r.zero_den  <= 1'b0;
      ctl0_r.eq_hit    <= eq0;
    end
  end

  // Add, subtract and conjugate go straight to a signed wide value.
  logic is_add0_r, is_sub0_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      is_add0_r <= (in_action == cna_pkg::ACT_ADD);
      is_sub0_r <= (in_action == cna_pkg::ACT_SUB);
    end
  end

  // Product stage: six signed products.
  logic signed [PW-1:0] ac_r, bd_r, ad_r, bc_r, cc_r, dd_r;
  logic signed [DW+1:0] lin_re_r, lin_im_r;
  cna_pkg::ctl_t        ctl1_r;
  cna_pkg::ctl_t        ctl1_nxt;

  always_comb begin
    ctl1_nxt           = ctl0_r;
    ctl1_nxt.is_addsub = is_add0_r || is_sub0_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ac_r <= a_r * c_r;
      bd_r <= b_r * d_r;
      ad_r <= a_r * d_r;
      bc_r <= b_r * c_r;
      cc_r <= c_r * c_r;
      dd_r <= d_r * d_r;
      ctl1_r <= ctl1_nxt;
      unique case (1'b1)
        is_add0_r: begin
          lin_re_r <= (DW+2)'(a_r) + (DW+2)'(c_r);
          lin_im_r <= (DW+2)'(b_r) + (DW+2)'(d_r);
        end
        is_sub0_r: begin
          lin_re_r <= (DW+2)'(a_r) - (DW+2)'(c_r);
          lin_im_r <= (DW+2)'(b_r) - (DW+2)'(d_r);
        end
        default: begin
          lin_re_r <= (DW+2)'(a_r);
          lin_im_r <= -(DW+2)'(b_r);
        end
      endcase
    end
  end

  // Sum stage: exact signed real and imaginary numerators, divisor.
  logic signed [SW:0]   sre, sim;
  logic signed [SW:0]   num_re_r, num_im_r;
  logic [DEN_W-1:0]     den_r;
  cna_pkg::ctl_t        ctl2_r;
  cna_pkg::ctl_t        ctl2_nxt;
  logic [DEN_W-1:0]     den_c;

  always_comb begin
    den_c = DEN_W'(cc_r) + DEN_W'(dd_r);
    if (ctl1_r.is_div) begin
      sre = (SW+1)'(ac_r) + (SW+1)'(bd_r);
      sim = (SW+1)'(bc_r) - (SW+1)'(ad_r);
    end else if (ctl1_r.is_mul) begin
      sre = (SW+1)'(ac_r) - (SW+1)'(bd_r);
      sim = (SW+1)'(ad_r) + (SW+1)'(bc_r);
    end else begin
      sre = (SW+1)'(lin_re_r);
      sim = (SW+1)'(lin_im_r);
    end
    ctl2_nxt          = ctl1_r;
    ctl2_nxt.zero_den = (den_c == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_re_r <= sre;
      num_im_r <= sim;
      den_r    <= den_c;
      ctl2_r   <= ctl2_nxt;
    end
  end

  // Division chain: magnitudes through NCELL cells, signs and control aside.
  logic [DEN_W-1:0] ch_den [NCELL+1];
  logic [DEN_W:0]   ch_rre [NCELL+1];
  logic [DEN_W:0]   ch_rim [NCELL+1];
  logic [NUM_W-1:0] ch_nre [NCELL+1];
  logic [NUM_W-1:0] ch_nim [NCELL+1];
  logic [Q_W-1:0]   ch_qre [NCELL+1];
  logic [Q_W-1:0]   ch_qim [NCELL+1];

  logic [SW-1:0] mag_re, mag_im;
  always_comb begin
    mag_re = num_re_r[SW] ? SW'(-num_re_r) : SW'(num_re_r);
    mag_im = num_im_r[SW] ? SW'(-num_im_r) : SW'(num_im_r);
  end

  assign ch_den[0] = ctl2_r.zero_den ? DEN_W'(1) : den_r;
  assign ch_rre[0] = '0;
  assign ch_rim[0] = '0;
  assign ch_nre[0] = {mag_re, {FRAC_BITS{1'b0}}};
  assign ch_nim[0] = {mag_im, {FRAC_BITS{1'b0}}};
  assign ch_qre[0] = '0;
  assign ch_qim[0] = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cna_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_cell (
      .clk      (clk),
      .adv      (adv),
      .den_i    (ch_den[i]),
      .rem_re_i (ch_rre[i]),
      .rem_im_i (ch_rim[i]),
      .num_re_i (ch_nre[i]),
      .num_im_i (ch_nim[i]),
      .q_re_i   (ch_qre[i]),
      .q_im_i   (ch_qim[i]),
      .den_o    (ch_den[i+1]),
      .rem_re_o (ch_rre[i+1]),
      .rem_im_o (ch_rim[i+1]),
      .num_re_o (ch_nre[i+1]),
      .num_im_o (ch_nim[i+1]),
      .q_re_o   (ch_qre[i+1]),
      .q_im_o   (ch_qim[i+1])
    );
  end

  // Side pipeline for signs, raw values and control alongside the cells.
  cna_pkg::ctl_t    sctl_r [NCELL];
  logic [SW:0]      sre_r  [NCELL];
  logic [SW:0]      sim_r  [NCELL];

  always_ff @(posedge clk) begin
    if (adv) begin
      sctl_r[0] <= ctl2_r;
      sre_r[0]  <= num_re_r;
      sim_r[0]  <= num_im_r;
      for (int k = 1; k < NCELL; k++) begin
        sctl_r[k] <= sctl_r[k-1];
        sre_r[k]  <= sre_r[k-1];
        sim_r[k]  <= sim_r[k-1];
      end
    end
  end

  // Final stage: pick magnitude, truncate, saturate.
  localparam logic [Q_W-1:0] HALF = Q_W'(1) << (DW - 1);
  cna_pkg::ctl_t  fc;
  logic           neg_re, neg_im;
  logic [SW:0]    abs_re, abs_im;
  logic [Q_W-1:0] m_re, m_im;
  logic [Q_W-1:0] lim_re, lim_im;
  logic           clip_re, clip_im;
  logic [DW-1:0]  v_re, v_im;
  logic           sat_c;

  always_comb begin
    fc     = sctl_r[NCELL-1];
    neg_re = sre_r[NCELL-1][SW];
    neg_im = sim_r[NCELL-1][SW];
    // The magnitude is taken at the full sum width before it is widened.
    abs_re = neg_re ? -sre_r[NCELL-1] : sre_r[NCELL-1];
    abs_im = neg_im ? -sim_r[NCELL-1] : sim_r[NCELL-1];
    if (fc.is_div) begin
      m_re = ch_qre[NCELL];
      m_im = ch_qim[NCELL];
    end else begin
      m_re = Q_W'(abs_re);
      m_im = Q_W'(abs_im);
      if (fc.is_mul) begin
        m_re = m_re >> FRAC_BITS;
        m_im = m_im >> FRAC_BITS;
      end
    end
    lim_re  = neg_re ? HALF : HALF - Q_W'(1);
    lim_im  = neg_im ? HALF : HALF - Q_W'(1);
    clip_re = m_re > lim_re;
    clip_im = m_im > lim_im;
    if (clip_re) m_re = lim_re;
    if (clip_im) m_im = lim_im;
    v_re = neg_re ? DW'(-m_re) : DW'(m_re);
    v_im = neg_im ? DW'(-m_im) : DW'(m_im);
    sat_c = clip_re || clip_im;
    if (fc.is_div && fc.zero_den) begin
      v_re  = '0;
      v_im  = '0;
      sat_c = 1'b0;
    end
    if (fc.is_conj) begin
      clip_re = 1'b0;
      sat_c   = clip_im;
    end
    if (!(fc.is_addsub || fc.is_mul || fc.is_div || fc.is_conj)) begin
      v_re  = '0;
      v_im  = '0;
      sat_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[PIPE-2:0], in_valid};
      out_valid_r <= vld_r[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result_re      <= cna_pkg::PORT_WIDTH'(signed'(v_re));
      out_result_im      <= cna_pkg::PORT_WIDTH'(signed'(v_im));
      out_is_equal       <= fc.is_eq && fc.eq_hit;
      out_divide_by_zero <= fc.is_div && fc.zero_den;
      out_saturated      <= sat_c;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/cna_div_cell.sv
// One restoring division cell that produces one quotient bit for two dividends.
module cna_div_cell #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 33,
  parameter int Q_W   = 64
) (
  input  logic             clk,
  input  logic             adv,
  input  logic [DEN_W-1:0] den_i,
  input  logic [DEN_W:0]   rem_re_i,
  input  logic [DEN_W:0]   rem_im_i,
  input  logic [NUM_W-1:0] num_re_i,
  input  logic [NUM_W-1:0] num_im_i,
  input  logic [Q_W-1:0]   q_re_i,
  input  logic [Q_W-1:0]   q_im_i,
  output logic [DEN_W-1:0] den_o,
  output logic [DEN_W:0]   rem_re_o,
  output logic [DEN_W:0]   rem_im_o,
  output logic [NUM_W-1:0] num_re_o,
  output logic [NUM_W-1:0] num_im_o,
  output logic [Q_W-1:0]   q_re_o,
  output logic [Q_W-1:0]   q_im_o
);

  logic [DEN_W:0] sh_re, sh_im;
  logic           qb_re, qb_im;

  always_comb begin
    sh_re = {rem_re_i[DEN_W-1:0], num_re_i[NUM_W-1]};
    sh_im = {rem_im_i[DEN_W-1:0], num_im_i[NUM_W-1]};
    qb_re = (sh_re >= {1'b0, den_i});
    qb_im = (sh_im >= {1'b0, den_i});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      den_o    <= den_i;
      rem_re_o <= qb_re ? sh_re - {1'b0, den_i} : sh_re;
      rem_im_o <= qb_im ? sh_im - {1'b0, den_i} : sh_im;
      num_re_o <= {num_re_i[NUM_W-2:0], 1'b0};
      num_im_o <= {num_im_i[NUM_W-2:0], 1'b0};
      q_re_o   <= {q_re_i[Q_W-2:0], qb_re};
      q_im_o   <= {q_im_i[Q_W-2:0], qb_im};
    end
  end

endmodule
